[sv/lcmac_pkg.sv]
// shared types and constants for the modular mac accumulator
`default_nettype none
package lcmac_pkg;
  localparam int LIMB_W = 64;
  localparam int LIMBS = 4;
  localparam int WORD_W = 256;
  localparam logic [7:0] Q_DELTA = 8'd189;
  localparam int BLOCK_BYTES = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_ACC,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

[sv/lcmac_mul.sv]
// shared 32x32 multiplier unit, one partial product per cycle
`default_nettype none
module lcmac_mul (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic      [63:0] prod
);
  // registered 32x32 partial product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end
endmodule
`default_nettype wire

[sv/modular_mac_accumulator_256_unit.sv]
// top level: buffers limbs, computes (a*m+b) mod q with a shared multiplier, accumulates tag
//
//  channel | dir | tdata fields (low bit up)                | tuser / tlast
//  s_axis  | in  | message_limb[63:0] key_a_limb[127:64]     | tuser=limb_position
//          |     | key_b_limb[191:128]                      | tlast=final_block
//  m_axis  | out | tag_limb[63:0]                           | tuser=tag_limb_index
//          |     |                                          | tlast=tag_last
//
// limbs 0..2 are only buffered; limb 3 starts 64 partial products of 32x32 through
// the registered multiplier, then reduction (ST_FOLD) and accumulation (ST_ACC),
// then four output transfers if final.
// the single 32x32 multiplier sets the block time.
// rst clears the accumulator and the sequencer; buffers are not reset.
// output stalls hold the sequencer in the output state.
`default_nettype none
module modular_mac_accumulator_256_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,  // message_limb, key_a_limb, key_b_limb
  input  wire logic [1:0]   s_axis_tuser,  // limb_position
  input  wire logic         s_axis_tlast,  // final_block
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [63:0]  m_axis_tdata,  // tag_limb
  output logic      [1:0]   m_axis_tuser,  // tag_limb_index
  output logic              m_axis_tlast   // tag_last
);
  lcmac_pkg::state_t state, state_next;
  logic [63:0] mbuf [4];
  logic [63:0] abuf [4];
  logic [63:0] bbuf [4];
  logic [255:0] acc;
  logic [511:0] prodacc;
  logic [264:0] fold;
  logic [5:0] step;
  logic [1:0] oidx;
  logic fin;
  logic [2:0] ai, mi;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [255:0] a_w, m_w, b_w;
  logic mul_vld;
  logic [5:0] pstep;

  assign a_w = {abuf[0], abuf[1], abuf[2], abuf[3]};
  assign m_w = {mbuf[0], mbuf[1], mbuf[2], mbuf[3]};
  assign b_w = {bbuf[0], bbuf[1], bbuf[2], bbuf[3]};

  // operand selection: step = {ai, mi}, 32-bit words least significant first
  assign ai = step[5:3];
  assign mi = step[2:0];
  assign op_a = a_w[32*ai +: 32];
  assign op_b = m_w[32*mi +: 32];

  lcmac_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lcmac_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tuser == 2'd3) state_next = lcmac_pkg::ST_MUL;
      lcmac_pkg::ST_MUL:
        if (mul_vld && pstep == 6'd63) state_next = lcmac_pkg::ST_FOLD;
      lcmac_pkg::ST_FOLD:
        if (step == 6'd2) state_next = lcmac_pkg::ST_ACC;
      lcmac_pkg::ST_ACC:
        if (step == 6'd2) state_next = fin ? lcmac_pkg::ST_OUT : lcmac_pkg::ST_IDLE;
      lcmac_pkg::ST_OUT:
        if (m_axis_tready && oidx == 2'd3) state_next = lcmac_pkg::ST_IDLE;
      default: state_next = lcmac_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == lcmac_pkg::ST_IDLE);
    m_axis_tvalid = (state == lcmac_pkg::ST_OUT);
    m_axis_tdata = acc[64*(2'd3 - oidx) +: 64];
    m_axis_tuser = oidx;
    m_axis_tlast = (oidx == 2'd3);
  end

  // input buffers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mbuf[s_axis_tuser] <= s_axis_tdata[63:0];
      abuf[s_axis_tuser] <= s_axis_tdata[127:64];
      bbuf[s_axis_tuser] <= s_axis_tdata[191:128];
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcmac_pkg::ST_IDLE;
      acc <= '0;
      step <= '0;
      oidx <= '0;
      fin <= 1'b0;
      mul_vld <= 1'b0;
      pstep <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        lcmac_pkg::ST_IDLE: begin
          step <= '0;
          oidx <= '0;
          mul_vld <= 1'b0;
          if (s_axis_tvalid) fin <= s_axis_tlast;
          prodacc <= '0;
        end
        lcmac_pkg::ST_MUL: begin
          if (step != 6'd63 || !mul_vld) step <= step + 6'd1;
          mul_vld <= 1'b1;
          pstep <= step;
          if (mul_vld)
            prodacc <= prodacc + ({448'd0, prod} << (32 * (pstep[5:3] + pstep[2:0])));
          if (mul_vld && pstep == 6'd63) step <= '0;
        end
        lcmac_pkg::ST_FOLD: begin
          step <= step + 6'd1;
          if (step == 6'd0) begin
            prodacc <= prodacc + {256'd0, b_w};
          end else if (step == 6'd1) begin
            fold <= {9'd0, prodacc[255:0]} + prodacc[511:256] * 9'(lcmac_pkg::Q_DELTA);
          end else begin
            fold <= {9'd0, fold[255:0]} + fold[264:256] * 9'(lcmac_pkg::Q_DELTA);
            step <= '0;
          end
        end
        lcmac_pkg::ST_ACC: begin
          step <= step + 6'd1;
          if (step == 6'd0) begin
            // add the term, folding its carry bit as 189
            fold <= {9'd0, fold[255:0]} + {9'd0, acc} +
                    (fold[256] ? 265'(lcmac_pkg::Q_DELTA) : 265'd0);
          end else if (step == 6'd1) begin
            // fold the carry of the sum
            fold <= {9'd0, fold[255:0]} + (fold[256] ? 265'(lcmac_pkg::Q_DELTA) : 265'd0);
          end else begin
            // final conditional subtract of q
            if (fold[255:0] >= -256'(lcmac_pkg::Q_DELTA))
              acc <= fold[255:0] + 256'(lcmac_pkg::Q_DELTA);
            else
              acc <= fold[255:0];
            step <= '0;
          end
        end
        lcmac_pkg::ST_OUT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[dv/testbench.sv]
// testbench for the modular mac accumulator: random limb streams checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  // tag accumulator model and queue of expected tag limbs
  class tag_scoreboard;
    logic [63:0]  msg_limbs [lcmac_pkg::LIMBS];
    logic [63:0]  key_a_limbs [lcmac_pkg::LIMBS];
    logic [63:0]  key_b_limbs [lcmac_pkg::LIMBS];
    logic [255:0] tag_sum;
    logic [65:0]  pending_tags [$];
    int           errors;

    function new();
      for (int i = 0; i < lcmac_pkg::LIMBS; i++) begin
        msg_limbs[i] = '0;
        key_a_limbs[i] = '0;
        key_b_limbs[i] = '0;
      end
      tag_sum = '0;
      errors = 0;
    endfunction

    // exact reduction mod q = 2^256 - 189, used for a*m+b and for the tag sum
    function automatic logic [255:0] reduce_mod_q(logic [512:0] val);
      logic [512:0] q;
      logic [512:0] v;
      q = (513'd1 << 256) - 513'd189;
      v = val;
      while (v[512:256] != 0)
        v = {257'd0, v[255:0]} + v[512:256] * 513'd189;
      if (v >= q) v = v - q;
      return v[255:0];
    endfunction

    function void note_input(logic [191:0] data, logic [1:0] pos, logic fin);
      logic [255:0] msg;
      logic [255:0] key_a;
      logic [255:0] key_b;
      logic [255:0] term;
      msg_limbs[pos] = data[63:0];
      key_a_limbs[pos] = data[127:64];
      key_b_limbs[pos] = data[191:128];
      if (pos != 2'd3) return;
      msg = {msg_limbs[0], msg_limbs[1], msg_limbs[2], msg_limbs[3]};
      key_a = {key_a_limbs[0], key_a_limbs[1], key_a_limbs[2], key_a_limbs[3]};
      key_b = {key_b_limbs[0], key_b_limbs[1], key_b_limbs[2], key_b_limbs[3]};
      term = reduce_mod_q(513'(key_a) * 513'(msg) + 513'(key_b));
      tag_sum = reduce_mod_q(513'(tag_sum) + 513'(term));
      if (!fin) return;
      for (int i = 0; i < lcmac_pkg::LIMBS; i++)
        pending_tags.push_back({tag_sum[255 - 64 * i -: 64], 2'(i)});
      tag_sum = '0;
    endfunction

    function void check_result(logic [63:0] limb, logic [1:0] idx, logic last);
      logic [65:0] exp_tag;
      if (pending_tags.size() == 0) begin
        $error("unexpected tag limb %h", limb);
        errors++;
        return;
      end
      exp_tag = pending_tags.pop_front();
      if (limb !== exp_tag[65:2]) begin
        $error("tag_limb expected %h actual %h", exp_tag[65:2], limb);
        errors++;
      end
      if (idx !== exp_tag[1:0]) begin
        $error("tag_limb_index expected %0d actual %0d", exp_tag[1:0], idx);
        errors++;
      end
      if (last !== (exp_tag[1:0] == 2'd3)) begin
        $error("tag_last expected %0d actual %0d", exp_tag[1:0] == 2'd3, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;  // message_limb, key_a_limb, key_b_limb
  logic [1:0]   s_axis_tuser = '0;  // limb_position
  logic         s_axis_tlast = 0;   // final_block
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;       // tag_limb
  logic [1:0]   m_axis_tuser;       // tag_limb_index
  logic         m_axis_tlast;       // tag_last

  tag_scoreboard sb = new();
  int            hold_off = 0;
  int            quiet_cycles = 0;

  modular_mac_accumulator_256_unit uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // one transfer into the block with a random gap in front
  task automatic send_limb(logic [191:0] data, logic [1:0] pos, logic fin, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tuser <= pos;
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(data, pos, fin);
  endtask

  function automatic logic [63:0] rand_limb(int mode);
    case (mode)
      0: return '0;
      1: return '1;
      2: return 64'hFFFF_FFFF_FFFF_FF43;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // full four-limb block; shape picks extreme or random limbs
  task automatic send_block(int shape, logic fin, bit no_gap);
    for (int p = 0; p < lcmac_pkg::LIMBS; p++)
      send_limb({rand_limb(shape), rand_limb(shape), rand_limb(shape)}, 2'(p), fin, no_gap);
  endtask

  // sink side: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 5) == 0) ? 0 : 1;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extreme operands, q-adjacent values, empty tag, final marks
    send_block(0, 1, 0);
    send_block(1, 1, 0);
    send_block(2, 0, 0);
    send_block(1, 1, 1);
    // final mark before position 3 is ignored; skipped and repeated positions
    send_limb({3{64'h0123_4567_89AB_CDEF}}, 2'd0, 1, 0);
    send_limb({3{64'hFEDC_BA98_7654_3210}}, 2'd3, 0, 0);
    send_limb({3{64'hFFFF_0000_FFFF_0000}}, 2'd1, 1, 0);
    send_limb({3{64'h0000_FFFF_0000_FFFF}}, 2'd1, 0, 0);
    send_limb({3{64'h8000_0000_0000_0001}}, 2'd3, 1, 0);
    // long output stall with input still offered
    hold_off = 300;
    repeat (3) send_block(3, 1, 1);
    // random messages, mostly well formed
    n = 0;
    while (n < 440) begin
      if ($urandom_range(0, 9) == 0) begin
        send_limb({rand_limb(3), rand_limb(3), rand_limb(3)}, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        n++;
      end else begin
        send_block($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : 3,
                   $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
        n += 4;
      end
    end
    s_axis_tvalid <= 0;
    while (sb.pending_tags.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/lcmac_pkg.sv
sv/lcmac_mul.sv
sv/modular_mac_accumulator_256_unit.sv
dv/testbench.sv
